// ----- rtl/assert_macros.svh -----
// Assertion shorthands, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/maf_pkg.sv -----
package maf_pkg;

    localparam int MAX_WINDOW     = 64;
    localparam int SAMPLE_BITS    = 16;
    localparam int PTR_BITS       = $clog2(MAX_WINDOW);
    localparam int LEN_BITS       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS       = SAMPLE_BITS + PTR_BITS;
    localparam int REM_BITS       = LEN_BITS + 1;
    localparam int DIV_CNT_BITS   = $clog2(SUM_BITS + 1);
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = LEN_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [SUM_BITS-1:0]    total_t;
    typedef logic [PTR_BITS-1:0]           ptr_t;
    typedef logic [LEN_BITS-1:0]           len_t;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_WINDOW_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SUM_MODE      = 2'd1;

    // sample store request
    typedef struct packed {
        logic    clear;
        logic    rd_en;
        ptr_t    rd_addr;
        logic    wr_en;
        ptr_t    wr_addr;
        sample_t wr_data;
    } store_req_t;

    // divider request: magnitude of the total, divisor, sign of the result
    typedef struct packed {
        logic                start;
        logic                neg;
        logic [SUM_BITS-1:0] magnitude;
        len_t                divisor;
    } div_req_t;

    typedef struct packed {
        logic    done;
        sample_t quotient;
    } div_resp_t;

endpackage

// ----- rtl/maf_store.sv -----
module maf_store (
    input  logic                clk,
    input  logic                rst_n,
    input  maf_pkg::store_req_t req,
    output maf_pkg::sample_t    rd_data
);

    maf_pkg::sample_t               mem [maf_pkg::MAX_WINDOW];
    logic [maf_pkg::MAX_WINDOW-1:0] valid_reg;
    maf_pkg::sample_t               rd_data_reg;

    // entries never written since the last clear read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/maf_div.sv -----
module maf_div (
    input  logic               clk,
    input  logic               rst_n,
    input  maf_pkg::div_req_t  req,
    output maf_pkg::div_resp_t resp
);

    logic                                busy_reg;
    logic                                done_reg;
    logic [maf_pkg::DIV_CNT_BITS-1:0]    count_reg;
    logic [maf_pkg::REM_BITS-1:0]        rem_reg;
    logic [maf_pkg::SUM_BITS-1:0]        quo_reg;
    logic [maf_pkg::LEN_BITS-1:0]        divisor_reg;
    logic                                neg_reg;

    logic [maf_pkg::REM_BITS-1:0]        shifted;
    logic [maf_pkg::REM_BITS:0]          diff;
    logic [maf_pkg::SUM_BITS-1:0]        signed_quo;

    // restoring division, one quotient bit per cycle, MSB first
    assign shifted = {rem_reg[maf_pkg::REM_BITS-2:0], quo_reg[maf_pkg::SUM_BITS-1]};
    assign diff    = {1'b0, shifted} - {2'b00, divisor_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= maf_pkg::DIV_CNT_BITS'(maf_pkg::SUM_BITS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == maf_pkg::DIV_CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.magnitude;
            divisor_reg <= req.divisor;
            neg_reg     <= req.neg;
        end
        else if (busy_reg)
        begin
            if (!diff[maf_pkg::REM_BITS])
            begin
                rem_reg <= diff[maf_pkg::REM_BITS-1:0];
                quo_reg <= {quo_reg[maf_pkg::SUM_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[maf_pkg::SUM_BITS-2:0], 1'b0};
            end
        end
    end

    // truncation toward zero: divide magnitudes, then restore the sign
    assign signed_quo    = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign resp.done     = done_reg;
    assign resp.quotient = signed_quo[maf_pkg::SAMPLE_BITS-1:0];

endmodule

// ----- rtl/moving_average_filter_core.sv -----
// Sequence per beat: store read on accept, total update and store write (ST_UPD),
//   then in average mode the bit-serial divider (ST_DIV), then the output register.
// One beat in flight: in_stall stays high until the result enters the output register,
//   so a stalled output register holds off the next beat.
// Reset (rst_n, async, active low): store reads as all zero, pointer and total
//   zero, window_length 1, sum_mode 0. No clearing pass: store entries carry valid bits.
module moving_average_filter_core (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_write_en,
    input  logic [maf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [maf_pkg::CFG_DATA_BITS-1:0]    cfg_data,

    // sample beats in
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic signed [maf_pkg::SAMPLE_BITS-1:0] sample,

    // filtered beats out
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [maf_pkg::SAMPLE_BITS-1:0] filtered
);

    typedef enum logic [1:0] {
        ST_IDLE,    // waiting for a sample beat
        ST_UPD,     // old entry back from the store: update total, write sample
        ST_DIV,     // divider running
        ST_OUT      // result ready, waiting for the output register
    } state_t;

    state_t              state_reg;
    logic                out_valid_reg;
    maf_pkg::sample_t    filtered_reg;

    // configuration
    maf_pkg::len_t       win_len_reg;
    logic                sum_mode_reg;

    // filter state outside the store
    maf_pkg::ptr_t       ptr_reg;
    maf_pkg::total_t     total_reg;

    // per-beat working registers
    maf_pkg::sample_t    sample_reg;
    maf_pkg::ptr_t       addr_reg;
    maf_pkg::sample_t    result_reg;

    logic                in_accept;
    logic                out_load;
    logic                len_write;
    maf_pkg::len_t       len_clamped;
    maf_pkg::ptr_t       ptr_eff;
    maf_pkg::ptr_t       ptr_next;
    maf_pkg::total_t     total_next;
    maf_pkg::sample_t    old_sample;
    maf_pkg::store_req_t store_req;
    maf_pkg::div_req_t   div_req;
    maf_pkg::div_resp_t  div_resp;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    // output register frees up when empty or when its beat is taken
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    // window length write: zero means one, anything above the store depth saturates
    assign len_write = cfg_write_en && (cfg_index == maf_pkg::CFG_WINDOW_LENGTH);

    always_comb
    begin
        len_clamped = cfg_data[maf_pkg::LEN_BITS-1:0];
        if (len_clamped == '0)
        begin
            len_clamped = maf_pkg::LEN_BITS'(1);
        end
        else if (len_clamped > maf_pkg::LEN_BITS'(maf_pkg::MAX_WINDOW))
        begin
            len_clamped = maf_pkg::LEN_BITS'(maf_pkg::MAX_WINDOW);
        end
    end

    // pointer stays below the window, the wrap check is only a guard
    assign ptr_eff  = ({1'b0, ptr_reg} >= win_len_reg) ? '0 : ptr_reg;
    assign ptr_next = (({1'b0, addr_reg} + 1'b1) >= win_len_reg) ? '0 : (addr_reg + 1'b1);

    // running total: add the new sample, drop the one it overwrites
    assign total_next = total_reg
                      + {{maf_pkg::PTR_BITS{sample_reg[maf_pkg::SAMPLE_BITS-1]}}, sample_reg}
                      - {{maf_pkg::PTR_BITS{old_sample[maf_pkg::SAMPLE_BITS-1]}}, old_sample};

    // store: read the oldest entry on accept, write the new sample in the next cycle (ST_UPD)
    always_comb
    begin
        store_req.clear   = len_write;
        store_req.rd_en   = in_accept;
        store_req.rd_addr = ptr_eff;
        store_req.wr_en   = (state_reg == ST_UPD);
        store_req.wr_addr = addr_reg;
        store_req.wr_data = sample_reg;
    end

    maf_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (old_sample)
    );

    // average mode: divide |total| by the window length
    always_comb
    begin
        div_req.start     = (state_reg == ST_UPD) && !sum_mode_reg;
        div_req.neg       = total_next[maf_pkg::SUM_BITS-1];
        div_req.magnitude = total_next[maf_pkg::SUM_BITS-1] ? (~total_next + 1'b1)
                                                            : total_next;
        div_req.divisor   = win_len_reg;
    end

    maf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // sequencer, output valid and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            filtered_reg  <= '0;
        end
        else
        begin
            // a new result takes the output register, else a taken beat empties it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                filtered_reg  <= result_reg;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        state_reg <= ST_UPD;
                    end
                end
                ST_UPD:
                begin
                    state_reg <= sum_mode_reg ? ST_OUT : ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_resp.done)
                    begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_len_reg  <= maf_pkg::LEN_BITS'(1);
            sum_mode_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                maf_pkg::CFG_WINDOW_LENGTH: win_len_reg  <= len_clamped;
                maf_pkg::CFG_SUM_MODE:      sum_mode_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    // pointer and total; a window length write restarts the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            total_reg <= '0;
        end
        else if (len_write)
        begin
            ptr_reg   <= '0;
            total_reg <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            ptr_reg   <= ptr_next;
            total_reg <= total_next;
        end
    end

    // per-beat payload
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            sample_reg <= sample;
            addr_reg   <= ptr_eff;
        end
        if (state_reg == ST_UPD)
        begin
            // sum mode wraps to the sample width
            result_reg <= total_next[maf_pkg::SAMPLE_BITS-1:0];
        end
        else if (div_resp.done)
        begin
            result_reg <= div_resp.quotient;
        end
    end

endmodule

// ----- rtl/maf_checker.sv -----
`include "assert_macros.svh"

module maf_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 cfg_write_en,
    input logic [maf_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input logic [maf_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input logic                                 in_valid,
    input logic                                 in_stall,
    input logic signed [maf_pkg::SAMPLE_BITS-1:0] sample,
    input logic                                 out_valid,
    input logic                                 out_stall,
    input logic signed [maf_pkg::SAMPLE_BITS-1:0] filtered
);

    // one beat in flight: input side closes right after a beat
    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "input open after beat")

    // a result only appears while a beat is being worked on
    `ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result with no beat")

    // stalled result holds
    `ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(filtered), "held beat moved")

endmodule

bind moving_average_filter_core maf_checker u_maf_checker (.*);

// ----- sim/tb_top.sv -----
module tb_top;

    // spare register indexes; writes there must leave the filter alone
    localparam logic [maf_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [maf_pkg::CFG_INDEX_BITS-1:0] CFG_SPARE_3 = 2'd3;

    localparam int ITEM_TARGET = 750;
    localparam int CYCLE_LIMIT = 300000;
    localparam int IDLE_PCT    = 27;

    // how random samples are spread
    typedef enum int {LEAN_ANY, LEAN_HIGH, LEAN_LOW} lean_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write_en;
    logic [maf_pkg::CFG_INDEX_BITS-1:0]  cfg_index;
    logic [maf_pkg::CFG_DATA_BITS-1:0]   cfg_data;
    logic                                in_valid;
    logic                                in_stall;
    maf_pkg::sample_t                    sample;
    logic                                out_valid;
    logic                                out_stall;
    maf_pkg::sample_t                    filtered;

    moving_average_filter_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .filtered     (filtered)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Filter predictor: private copy of the sample window and registers.
    // ------------------------------------------------------------------
    maf_pkg::sample_t held_samples [maf_pkg::MAX_WINDOW];
    int unsigned      next_slot;
    longint           running_total;
    int unsigned      active_length;
    bit               total_mode;

    maf_pkg::sample_t expected_filtered [$];

    int          fail_count;
    int          sent_count;
    int          result_count;
    int          setting_count;
    int          cycle_count;

    // gap control for both sides, and the receiver hold-off request
    bit          in_gaps_on;
    bit          out_gaps_on;
    int          holdoff_request;

    function automatic void clear_window();
        foreach (held_samples[i])
            held_samples[i] = '0;
        next_slot     = 0;
        running_total = 0;
    endfunction

    // register write as the block sees it: length clamped, mode takes bit 0
    function automatic void apply_register(logic [maf_pkg::CFG_INDEX_BITS-1:0] idx,
                                           logic [maf_pkg::CFG_DATA_BITS-1:0] data);
        int unsigned len;
        if (idx == maf_pkg::CFG_WINDOW_LENGTH)
        begin
            len = data;
            if (len == 0)
                len = 1;
            if (len > maf_pkg::MAX_WINDOW)
                len = maf_pkg::MAX_WINDOW;
            clear_window();
            active_length = len;
        end
        else if (idx == maf_pkg::CFG_SUM_MODE)
        begin
            total_mode = data[0];
        end
    endfunction

    // new sample replaces the oldest entry; total kept wide, result cut to 16 bits
    function automatic maf_pkg::sample_t predict_filtered(maf_pkg::sample_t s);
        longint r;
        if (next_slot >= active_length)
            next_slot = 0;
        running_total += longint'(s) - longint'(held_samples[next_slot]);
        held_samples[next_slot] = s;
        next_slot++;
        if (next_slot >= active_length)
            next_slot = 0;
        if (total_mode)
            r = running_total;
        else
            r = running_total / longint'(active_length);   // truncates toward zero
        return maf_pkg::sample_t'(r[maf_pkg::SAMPLE_BITS-1:0]);
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0d] MISMATCH: %s", cycle_count, what);
        fail_count++;
    endtask

    function automatic maf_pkg::sample_t pick_sample(lean_t lean);
        case (lean)
            LEAN_HIGH: return maf_pkg::sample_t'(16'h7FFF - $urandom_range(0, 2047));
            LEAN_LOW:  return maf_pkg::sample_t'(16'h8000 + $urandom_range(0, 2047));
            default:
            begin
                if ($urandom_range(99) < 12)
                begin
                    case ($urandom_range(4))
                        0: return 16'sh7FFF;
                        1: return 16'sh8000;
                        2: return 16'sh0000;
                        3: return 16'shFFFF;
                        default: return 16'sh0001;
                    endcase
                end
                return maf_pkg::sample_t'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side. All tasks start and end on a rising edge.
    // ------------------------------------------------------------------

    // One input beat. Valid stays high on return, so back-to-back beats
    // need no second assignment in the same step; an optional gap lowers it.
    task automatic send_sample(input maf_pkg::sample_t value);
        int  gap;
        bit  taken;
        gap = 0;
        if (in_gaps_on && $urandom_range(99) < IDLE_PCT)
            gap = $urandom_range(1, 6);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        // stall is settled by the falling edge and held until the next rise
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        expected_filtered.push_back(predict_filtered(value));
        sent_count++;
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_filtered.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Only called with the block idle.
    task automatic write_register(input logic [maf_pkg::CFG_INDEX_BITS-1:0] idx,
                                  input logic [maf_pkg::CFG_DATA_BITS-1:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        apply_register(idx, data);
        @(posedge clk);
        setting_count++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall, hold-off counted here, one check per beat.
    // ------------------------------------------------------------------
    initial
    begin
        int               hold_left;
        bit               take;
        maf_pkg::sample_t got;
        maf_pkg::sample_t want;
        out_stall <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            take = rst_n && (out_valid === 1'b1) && !out_stall;
            got  = filtered;
            @(posedge clk);
            if (take)
            begin
                result_count++;
                if (expected_filtered.size() == 0)
                    report_mismatch($sformatf("filtered %0d with no sample pending", got));
                else
                begin
                    want = expected_filtered.pop_front();
                    if (got !== want)
                        report_mismatch($sformatf("filtered %0d, predicted %0d (window %0d, mode %0d)",
                                                  got, want, active_length, total_mode));
                end
            end
            if (holdoff_request > 0)
            begin
                hold_left       = holdoff_request;
                holdoff_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= out_gaps_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // reset state: window of one, average mode, so output follows input
    task automatic test_reset_defaults();
        send_sample(16'sh7FFF);
        send_sample(16'sh8000);
        send_sample(16'sh0000);
        send_sample(16'shFFFF);
        wait_for_results();
    endtask

    // length zero acts as one; lengths past 64 saturate; partial window
    // still divides by the full length, negative averages truncate toward zero
    task automatic test_length_clamps();
        write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'd0);
        send_sample(16'sh1234);
        send_sample(16'shEDCB);
        wait_for_results();
        write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'd127);
        send_sample(16'sh8000);
        send_sample(16'sh8000);
        send_sample(16'shFFFF);
        wait_for_results();
    endtask

    // wrapped sum at the widest window, then mode bit masking and spare indexes
    task automatic test_sum_mode_wrap();
        write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'd65);
        write_register(maf_pkg::CFG_SUM_MODE, 7'h7F);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        send_sample(16'sh7FFF);
        wait_for_results();
        // bit 0 clear, upper bits set: back to average, store kept
        write_register(maf_pkg::CFG_SUM_MODE, 7'h7E);
        write_register(CFG_SPARE_2, 7'h7F);
        write_register(CFG_SPARE_3, 7'h01);
        send_sample(16'sh8000);
        send_sample(16'sh0001);
        wait_for_results();
    endtask

    // a length write mid-stream empties the window
    task automatic test_length_rewrite_clears();
        write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'd3);
        send_sample(16'sh4000);
        send_sample(16'sh4000);
        wait_for_results();
        write_register(maf_pkg::CFG_SUM_MODE, 7'h00);
        write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'd3);
        send_sample(16'shFFFF);
        send_sample(16'shFFFF);
        send_sample(16'sh7FFF);
        wait_for_results();
    endtask

    // receiver holds off for a long stretch while beats keep coming,
    // so the block backs up and stalls its input
    task automatic test_output_holdoff();
        write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'd8);
        write_register(maf_pkg::CFG_SUM_MODE, 7'h01);
        holdoff_request = 300;
        repeat (16)
            send_sample(pick_sample(LEAN_ANY));
        wait_for_results();
        write_register(maf_pkg::CFG_SUM_MODE, 7'h00);
        holdoff_request = 200;
        repeat (6)
            send_sample(pick_sample(LEAN_LOW));
        wait_for_results();
    endtask

    // random settings, each phase drained before the next setting
    task automatic test_random_traffic();
        int    phase;
        int    n;
        int    roll;
        lean_t lean;
        phase = 0;
        while (sent_count < ITEM_TARGET)
        begin
            in_gaps_on  = 1'b1;
            out_gaps_on = 1'b1;
            n = $urandom_range(20, 50);
            case (phase)
                0:
                begin
                    write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'd1);
                    write_register(maf_pkg::CFG_SUM_MODE, 7'h01);
                end
                1:
                begin
                    write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'd64);
                    write_register(maf_pkg::CFG_SUM_MODE, 7'h01);
                    n = 90;
                end
                2:
                begin
                    // switch mode only: the full window carries over
                    write_register(maf_pkg::CFG_SUM_MODE, 7'h00);
                end
                3:
                begin
                    // long stretch with both sides running flat out
                    write_register(maf_pkg::CFG_WINDOW_LENGTH, 7'($urandom_range(2, 64)));
                    in_gaps_on  = 1'b0;
                    out_gaps_on = 1'b0;
                    n = 90;
                end
                default:
                begin
                    if ($urandom_range(99) < 80)
                        write_register(maf_pkg::CFG_WINDOW_LENGTH,
                                       7'($urandom_range(0, 127)));
                    write_register(maf_pkg::CFG_SUM_MODE, 7'($urandom_range(0, 127)));
                end
            endcase
            roll = $urandom_range(99);
            if (roll < 25)
                lean = LEAN_HIGH;
            else if (roll < 40)
                lean = LEAN_LOW;
            else
                lean = LEAN_ANY;
            repeat (n)
                send_sample(pick_sample(lean));
            wait_for_results();
            phase++;
        end
        in_gaps_on  = 1'b1;
        out_gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Run-length guard
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d beats still pending",
                 cycle_count, expected_filtered.size());
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        sample       <= '0;
        cfg_write_en <= 1'b0;
        cfg_index    <= maf_pkg::CFG_WINDOW_LENGTH;
        cfg_data     <= '0;
        fail_count      = 0;
        sent_count      = 0;
        result_count    = 0;
        setting_count   = 0;
        holdoff_request = 0;
        in_gaps_on      = 1'b1;
        out_gaps_on     = 1'b1;
        clear_window();
        active_length = 1;
        total_mode    = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_length_clamps();
        test_sum_mode_wrap();
        test_length_rewrite_clears();
        test_output_holdoff();
        test_random_traffic();

        // catch any stray beat past the average-mode latency
        wait_for_results();
        repeat (maf_pkg::SUM_BITS + 10) @(posedge clk);

        $display("Covered %0d samples and %0d filtered beats across %0d register writes,",
                 sent_count, result_count, setting_count);
        $display("window lengths 1..64 with clamping, average and wrapped-sum modes, back-pressure.");
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
